### design/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, quiet while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on clk, quiet while rst is high.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bphq_pkg.sv
// Types and constants of the button press and hold qualifier.
`default_nettype none

package bphq_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int CMP_BITS   = ((TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS) + 1;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(5);
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(200);

  // register word index, taken from paddr[2]
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_DEBOUNCING = 3'd1,
    PH_PRESSED    = 3'd2,
    PH_HELD       = 3'd3,
    PH_DOWN       = 3'd4,
    PH_RELEASED   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ticks;
    logic [CFG_BITS-1:0] long_press_ticks;
  } cfg_t;

endpackage

`default_nettype wire

### design/button_press_hold_qualifier.sv
// Top level of the button press and hold qualifier.
`default_nettype none
`include "assert_macros.svh"

// Each input transaction is one timer tick carrying the sampled button level; each
// tick yields exactly one result transaction with the updated phase and one-tick
// released/held event flags. Results appear in the cycle after acceptance, and a new
// tick is taken every cycle: the phase and timer update is a single compare and
// increment between the state registers and the result register, and the input
// side stays ready while the result register is empty or being drained. Debounce
// and long-press limits (in ticks) are set over APB at addresses 0x0 and 0x4;
// they should be written only while no tick is in flight.
module button_press_hold_qualifier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] button_level, [7:1] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [2:0] button_phase, [3] release_event,
                                      // [4] hold_event, [7:5] zero
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import bphq_pkg::*;

  cfg_t                  cfg;
  phase_t                phase;
  phase_t                phase_next;
  logic [TIMER_BITS-1:0] tick_timer;
  logic [TIMER_BITS-1:0] tick_timer_next;
  logic                  s_accept;
  phase_t                out_phase;

  bphq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bphq_step u_step (
    .phase           (phase),
    .tick_timer      (tick_timer),
    .button_level    (s_tdata[0]),
    .cfg             (cfg),
    .phase_next      (phase_next),
    .tick_timer_next (tick_timer_next)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_timer <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (s_accept) begin
        phase      <= phase_next;
        tick_timer <= tick_timer_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid   <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_phase <= phase_next;
    end
  end

  assign m_tdata = {3'b000, out_phase == PH_HELD, out_phase == PH_RELEASED, out_phase};

  // state moves only on an accepted tick
  `ASSERT_IMPL(a_state_holds, !s_accept, $stable(phase) && $stable(tick_timer), "state changed without a tick")
  // a held phase always leaves for down or idle on the next tick
  `ASSERT_IMPL(a_held_exit, s_accept && phase == PH_HELD, phase == PH_DOWN || phase == PH_IDLE, "bad exit from held")
  // input side only stalls behind a pending result
  `ASSERT_CLK(a_stall_cause, !s_tready |-> m_tvalid, "input stalled with empty result register")
  // result register reflects the state after the last accepted tick
  `ASSERT_IMPL(a_result_match, s_accept, out_phase == phase, "result phase differs from state")

endmodule

`default_nettype wire

### design/bphq_cfg.sv
// Configuration register file behind the APB port.
`default_nettype none

module bphq_cfg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output bphq_pkg::cfg_t        cfg
);
  import bphq_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_DEBOUNCE:   cfg.debounce_ticks   <= pwdata[CFG_BITS-1:0];
        REG_LONG_PRESS: cfg.long_press_ticks <= pwdata[CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEBOUNCE:   prdata = 32'(cfg.debounce_ticks);
      REG_LONG_PRESS: prdata = 32'(cfg.long_press_ticks);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/bphq_step.sv
// Next phase and tick timer for one tick.
`default_nettype none

module bphq_step (
  input  wire bphq_pkg::phase_t                  phase,
  input  wire logic [bphq_pkg::TIMER_BITS-1:0]   tick_timer,
  input  wire logic                              button_level,
  input  wire bphq_pkg::cfg_t                    cfg,
  output bphq_pkg::phase_t                       phase_next,
  output logic [bphq_pkg::TIMER_BITS-1:0]        tick_timer_next
);
  import bphq_pkg::*;

  logic [TIMER_BITS-1:0] bumped;
  logic                  debounce_done;
  logic                  long_reached;

  // timer saturates at all ones
  assign bumped = (&tick_timer) ? tick_timer : tick_timer + TIMER_BITS'(1);

  assign debounce_done = CMP_BITS'(bumped) >= CMP_BITS'(cfg.debounce_ticks);
  assign long_reached  = CMP_BITS'(tick_timer) >= CMP_BITS'(cfg.long_press_ticks);

  always_comb begin
    phase_next      = phase;
    tick_timer_next = tick_timer;
    unique case (phase)
      PH_IDLE: begin
        if (button_level) begin
          phase_next      = PH_DEBOUNCING;
          tick_timer_next = '0;
        end
      end
      PH_DEBOUNCING: begin
        if (debounce_done) begin
          phase_next      = PH_PRESSED;
          tick_timer_next = '0;
        end else begin
          tick_timer_next = bumped;
        end
      end
      PH_PRESSED, PH_DOWN: begin
        if (!button_level) begin
          phase_next = (phase == PH_PRESSED) ? PH_RELEASED : PH_IDLE;
        end else if (long_reached) begin
          phase_next = PH_HELD;
        end else begin
          tick_timer_next = bumped;
        end
      end
      PH_HELD: begin
        if (!button_level) begin
          phase_next = PH_IDLE;
        end else begin
          phase_next      = PH_DOWN;
          tick_timer_next = '0;
        end
      end
      PH_RELEASED: phase_next = PH_IDLE;
      default:     phase_next = PH_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for button_press_hold_qualifier: tick stream against a phase predictor.
`timescale 1ns / 100ps

module tb_top;
  import bphq_pkg::*;

  class press_scoreboard;
    logic [CFG_BITS-1:0]   debounce_limit;
    logic [CFG_BITS-1:0]   long_press_limit;
    logic [TIMER_BITS-1:0] tick_timer;
    phase_t                phase;
    logic [7:0]            pending_results[$];
    int                    mismatches;

    function new();
      debounce_limit   = DEBOUNCE_RESET;
      long_press_limit = LONG_PRESS_RESET;
      phase            = PH_IDLE;
      tick_timer       = '0;
      mismatches       = 0;
    endfunction

    function void set_limit(logic reg_sel, logic [CFG_BITS-1:0] value);
      if (reg_sel == REG_DEBOUNCE) begin
        debounce_limit = value;
      end else begin
        long_press_limit = value;
      end
    endfunction

    // timer sticks at all ones
    function void bump_timer();
      if (tick_timer != '1) tick_timer++;
    endfunction

    function void record_tick(logic level);
      case (phase)
        PH_IDLE: begin
          if (level) begin
            phase      = PH_DEBOUNCING;
            tick_timer = '0;
          end
        end
        PH_DEBOUNCING: begin
          bump_timer();
          if (tick_timer >= debounce_limit) begin
            phase      = PH_PRESSED;
            tick_timer = '0;
          end
        end
        PH_PRESSED, PH_DOWN: begin
          if (!level) begin
            phase = (phase == PH_PRESSED) ? PH_RELEASED : PH_IDLE;
          end else if (tick_timer >= long_press_limit) begin
            phase = PH_HELD;
          end else begin
            bump_timer();
          end
        end
        PH_HELD: begin
          if (!level) begin
            phase = PH_IDLE;
          end else begin
            phase      = PH_DOWN;
            tick_timer = '0;
          end
        end
        default: phase = PH_IDLE;
      endcase
      pending_results.push_back({3'b000, phase == PH_HELD, phase == PH_RELEASED, phase});
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with none expected: %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got[2:0] !== want[2:0] || got[3] !== want[3] || got[4] !== want[4]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch phase %0d/%0d release %b/%b hold %b/%b (exp/act)",
                   $time, want[2:0], got[2:0], want[3], got[3], want[4], got[4]);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  press_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  bit              stall_req = 1'b0;
  int              ticks_sent = 0;

  always #1 clk = ~clk;

  button_press_hold_qualifier uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [0] button_level, [7:1] zero
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [2:0] button_phase, [3] release_event, [4] hold_event
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  task automatic send_tick(input logic level);
    while (gaps_on && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, level};
    do @(posedge clk); while (!s_tready);
    sb.record_tick(level);
    ticks_sent++;
  endtask

  // bits go out from the left
  task automatic send_pattern(input logic [15:0] bits, input int n);
    for (int k = 0; k < n; k++) send_tick(bits[n-1-k]);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [CFG_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(reg_sel, value);
    @(posedge clk);
  endtask

  task automatic apb_check_read(input logic reg_sel, input logic [CFG_BITS-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_BITS-1:0] !== want) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("%0t: register %0d read %0d, expected %0d", $time, reg_sel,
                 prdata[CFG_BITS-1:0], want);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input int db, input int lp);
    wait_for_results();
    apb_write(REG_DEBOUNCE, CFG_BITS'(db));
    apb_write(REG_LONG_PRESS, CFG_BITS'(lp));
    apb_check_read(REG_DEBOUNCE, CFG_BITS'(db));
    apb_check_read(REG_LONG_PRESS, CFG_BITS'(lp));
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_req) begin
        stall_req  = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 32);
      end
    end
  end

  initial begin : stimulus
    int db_lim, lp_lim, phase_end, hold_len;
    rst     = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = 3'd0;
    pwdata  = 32'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    apb_check_read(REG_DEBOUNCE, DEBOUNCE_RESET);
    apb_check_read(REG_LONG_PRESS, LONG_PRESS_RESET);
    // short press with reset limits: debounce, pressed, released, idle
    send_pattern(16'b1111_1100, 8);

    // zero limits: instant accept, held on first pressed tick, down, repeats
    set_limits(0, 0);
    send_pattern(16'b1011_1101_1010_1110, 16);

    for (int p = 0; ticks_sent < 1500; p++) begin
      case (p % 4)
        0: begin
          db_lim = $urandom_range(0, 4);
          lp_lim = $urandom_range(0, 8);
        end
        1: begin
          db_lim = $urandom_range(1, 20);
          lp_lim = $urandom_range(1, 40);
        end
        2: begin
          db_lim = $urandom_range(0, 1);
          lp_lim = $urandom_range(0, 1);
        end
        default: begin
          db_lim = $urandom_range(0, 3);
          lp_lim = $urandom_range(50, 100);
        end
      endcase
      set_limits(db_lim, lp_lim);
      if (p == 1) stall_req = 1'b1;
      gaps_on   = (p != 3);
      phase_end = ticks_sent + 150;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(1)));
        end else begin
          hold_len = 1 + $urandom_range(db_lim + 1) + $urandom_range(0, 3) * (lp_lim + 1)
                     + $urandom_range(0, 2);
          // a few bounces inside the press
          repeat (hold_len) send_tick($urandom_range(99) >= 3);
          repeat ($urandom_range(1, 3)) send_tick(1'b0);
        end
      end
    end

    // largest limits: debounce that never completes, then cut short by a new limit
    set_limits(65535, 65535);
    gaps_on = 1'b0;
    repeat (40) send_tick(1'b1);
    // press that never reaches the long-press limit
    set_limits(1, 65535);
    repeat (60) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    gaps_on = 1'b1;

    wait_for_results();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("** button_press_hold_qualifier: PASSED **");
    end else begin
      $display("** button_press_hold_qualifier: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("** button_press_hold_qualifier: FAILED **");
    $finish;
  end

endmodule

### button_press_hold_qualifier.f
+incdir+design
design/bphq_pkg.sv
design/bphq_cfg.sv
design/bphq_step.sv
design/button_press_hold_qualifier.sv
verif/tb_top.sv
